>>> rtl/bfdh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfdh_pkg
// Types and constants shared by the double-hashing bloom filter block.
// ----------------------------------------------------------------------------
package bfdh_pkg;

    localparam int KEY_W          = 64;
    localparam int HASH_COUNT_W   = 6;
    localparam int FILTER_BITS_W  = 17;
    localparam int COUNT_W        = 32;
    localparam int MAX_HASHES     = 32;
    localparam int DIV_STEP       = 4;
    localparam int DIV_ITERS      = KEY_W / DIV_STEP;
    localparam int WORD_W         = 64;
    localparam int BIT_SEL_W      = 6;

    localparam logic [31:0] MIX_CONST = 32'h5bd1e995;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic CFG_HASH_COUNT  = 1'b0;
    localparam logic CFG_FILTER_BITS = 1'b1;

    localparam logic [HASH_COUNT_W-1:0]  HASH_COUNT_RST  = 6'd3;
    localparam logic [FILTER_BITS_W-1:0] FILTER_BITS_RST = 17'h10000;

    typedef struct packed {
        logic [1:0]       mode;
        logic [KEY_W-1:0] key_hash;
    } req_t;

    typedef struct packed {
        logic               maybe_present;
        logic [COUNT_W-1:0] stored_count;
    } rsp_t;

endpackage
`default_nettype wire

>>> rtl/bfdh_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfdh_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfdh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/bloom_filter_double_hash_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_top
// Bloom filter with double hashing over a word-wide bit store in RAM.
// ----------------------------------------------------------------------------
// usage:
//   a request (mode, key_hash) is taken when start is high and busy is low.
//   insert sets the probed bits, query tests them, clear wipes the filter.
//   each request yields one result on rsp, marked by a one-cycle done pulse;
//   the receiver cannot stall, so the result must be taken in that cycle.
//   configuration (hash_count, filter_bits) is written through cfg_we,
//   cfg_addr and cfg_wdata while busy is low.
// sequence:
//   insert/query: once the request is taken, the block runs the mix
//   multiply on one 32x32 multiplier (ST_MUL_LO, ST_MUL_HI), the sum,
//   three remainder lanes at 4 bits a cycle and the fixup, then issues
//   the limited probes one per cycle with forwarding and drains the last
//   read-modify-write; busy stays high throughout, done pulses as it falls.
//   clear: zeroes the store one word a cycle; done pulses as busy falls.
//   an undefined mode answers in the cycle after it is taken.
// reset:
//   after reset the block sweeps zeros through the store, one word a cycle,
//   with busy high until the sweep ends; configuration writes still land.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_top
    import bfdh_pkg::*;
#(
    parameter int MAX_BITS = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire req_t                     req,
    output logic                          done,
    output rsp_t                          rsp,
    input  wire logic                     cfg_we,
    input  wire logic                     cfg_addr,
    input  wire logic [FILTER_BITS_W-1:0] cfg_wdata
);

    localparam int WORDS  = (MAX_BITS + WORD_W - 1) / WORD_W;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int NB     = $clog2(MAX_BITS + 1);
    localparam int CMP_W  = (NB > FILTER_BITS_W) ? NB : FILTER_BITS_W;
    localparam int DIV_CW = $clog2(DIV_ITERS);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MUL_LO = 3'd2;
    localparam logic [2:0] ST_MUL_HI = 3'd3;
    localparam logic [2:0] ST_SUM    = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_FIX    = 3'd6;
    localparam logic [2:0] ST_PROBE  = 3'd7;

    // control state
    logic [2:0]               state_reg, state_next;
    logic                     clr_item_reg, clr_item_next;
    logic [AW-1:0]            clr_cnt_reg, clr_cnt_next;
    logic [DIV_CW-1:0]        div_cnt_reg, div_cnt_next;
    logic [HASH_COUNT_W-1:0]  iss_cnt_reg, iss_cnt_next;
    logic                     rd_pend_reg, rd_pend_next;
    logic                     fwd_valid_reg, fwd_valid_next;
    logic                     done_reg, done_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic [HASH_COUNT_W-1:0]  hash_count_reg, hash_count_next;
    logic [FILTER_BITS_W-1:0] filter_bits_reg, filter_bits_next;

    // datapath
    logic [1:0]              mode_reg, mode_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [HASH_COUNT_W-1:0] n_hash_reg, n_hash_next;
    logic [NB-1:0]           n_bits_reg, n_bits_next;
    logic [63:0]             prod_lo_reg, prod_lo_next;
    logic [31:0]             prod_hi_reg, prod_hi_next;
    logic [KEY_W-1:0]        second_reg, second_next;
    logic [KEY_W-1:0]        key_sh_reg, key_sh_next;
    logic [KEY_W-1:0]        sec_sh_reg, sec_sh_next;
    logic [NB-1:0]           rem_key_reg, rem_key_next;
    logic [NB-1:0]           rem_sec_reg, rem_sec_next;
    logic [NB-1:0]           rem_ones_reg, rem_ones_next;
    logic [NB-1:0]           wrap_reg, wrap_next;
    logic [NB-1:0]           s_mod_reg, s_mod_next;
    logic [NB-1:0]           r_reg, r_next;
    logic [KEY_W-1:0]        h_reg, h_next;
    logic [AW-1:0]           rd_addr_reg, rd_addr_next;
    logic [BIT_SEL_W-1:0]    rd_bit_reg, rd_bit_next;
    logic [AW-1:0]           fwd_addr_reg, fwd_addr_next;
    logic [WORD_W-1:0]       fwd_data_reg, fwd_data_next;
    logic                    present_reg, present_next;
    rsp_t                    rsp_reg, rsp_next;

    // store port
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic [31:0]             mul_a;
    logic [63:0]             mul_p;
    logic [HASH_COUNT_W-1:0] eff_hash;
    logic [NB-1:0]           eff_bits;

    function automatic logic [NB-1:0] mod_step(
        input logic [NB-1:0] rem,
        input logic          b,
        input logic [NB-1:0] n
    );
        logic [NB:0] t;
        t = {rem, b};
        if (t >= {1'b0, n})
        begin
            t = t - {1'b0, n};
        end
        return t[NB-1:0];
    endfunction

    bfdh_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign mul_p = 64'(mul_a) * 64'(MIX_CONST);

    // effective probe count and modulus
    always_comb
    begin
        logic [CMP_W-1:0] fb_ext;
        fb_ext = CMP_W'(filter_bits_reg);
        if ({1'b0, hash_count_reg} > 7'(MAX_HASHES))
        begin
            eff_hash = HASH_COUNT_W'(MAX_HASHES);
        end
        else
        begin
            eff_hash = hash_count_reg;
        end
        priority if (fb_ext == '0)
        begin
            eff_bits = NB'(1);
        end
        else if (fb_ext > CMP_W'(MAX_BITS))
        begin
            eff_bits = NB'(MAX_BITS);
        end
        else
        begin
            eff_bits = NB'(fb_ext);
        end
    end

    always_comb
    begin
        logic              issue;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] bit_mask;
        logic [KEY_W:0]    h_sum;
        logic [NB:0]       r1;
        logic [NB:0]       r2;
        logic [NB:0]       w1;
        logic [NB-1:0]     rk, rs, ro;

        state_next       = state_reg;
        clr_item_next    = clr_item_reg;
        clr_cnt_next     = clr_cnt_reg;
        div_cnt_next     = div_cnt_reg;
        iss_cnt_next     = iss_cnt_reg;
        rd_pend_next     = 1'b0;
        fwd_valid_next   = 1'b0;
        done_next        = 1'b0;
        count_next       = count_reg;
        hash_count_next  = hash_count_reg;
        filter_bits_next = filter_bits_reg;

        mode_next     = mode_reg;
        key_next      = key_reg;
        n_hash_next   = n_hash_reg;
        n_bits_next   = n_bits_reg;
        prod_lo_next  = prod_lo_reg;
        prod_hi_next  = prod_hi_reg;
        second_next   = second_reg;
        key_sh_next   = key_sh_reg;
        sec_sh_next   = sec_sh_reg;
        rem_key_next  = rem_key_reg;
        rem_sec_next  = rem_sec_reg;
        rem_ones_next = rem_ones_reg;
        wrap_next     = wrap_reg;
        s_mod_next    = s_mod_reg;
        r_next        = r_reg;
        h_next        = h_reg;
        rd_addr_next  = rd_addr_reg;
        rd_bit_next   = rd_bit_reg;
        fwd_addr_next = fwd_addr_reg;
        fwd_data_next = fwd_data_reg;
        present_next  = present_reg;
        rsp_next      = rsp_reg;

        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = '0;
        ram_raddr = AW'(r_reg >> BIT_SEL_W);
        mul_a     = key_reg[31:0];

        issue    = 1'b0;
        word     = ram_rdata;
        bit_mask = '0;
        h_sum    = '0;
        r1       = '0;
        r2       = '0;
        w1       = '0;
        rk       = rem_key_reg;
        rs       = rem_sec_reg;
        ro       = rem_ones_reg;

        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_HASH_COUNT:  hash_count_next  = cfg_wdata[HASH_COUNT_W-1:0];
                CFG_FILTER_BITS: filter_bits_next = cfg_wdata;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == AW'(WORDS - 1))
                begin
                    state_next = ST_IDLE;
                    if (clr_item_reg)
                    begin
                        done_next              = 1'b1;
                        rsp_next.maybe_present = 1'b0;
                        rsp_next.stored_count  = '0;
                    end
                    clr_item_next = 1'b0;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next   = req.mode;
                    key_next    = req.key_hash;
                    n_hash_next = eff_hash;
                    n_bits_next = eff_bits;
                    unique case (req.mode)
                        MODE_INSERT, MODE_QUERY:
                        begin
                            state_next = ST_MUL_LO;
                        end
                        MODE_CLEAR:
                        begin
                            state_next    = ST_CLEAR;
                            clr_cnt_next  = '0;
                            clr_item_next = 1'b1;
                            count_next    = '0;
                        end
                        default:
                        begin
                            // undefined mode leaves the state alone
                            done_next              = 1'b1;
                            rsp_next.maybe_present = 1'b0;
                            rsp_next.stored_count  = count_reg;
                        end
                    endcase
                end
            end

            ST_MUL_LO:
            begin
                mul_a        = key_reg[31:0];
                prod_lo_next = mul_p;
                state_next   = ST_MUL_HI;
            end

            ST_MUL_HI:
            begin
                // only the low half of the upper product survives mod 2^64
                mul_a        = key_reg[63:32];
                prod_hi_next = mul_p[31:0];
                state_next   = ST_SUM;
            end

            ST_SUM:
            begin
                second_next   = prod_lo_reg + {prod_hi_reg, 32'd0};
                key_sh_next   = key_reg;
                sec_sh_next   = second_next;
                rem_key_next  = '0;
                rem_sec_next  = '0;
                rem_ones_next = '0;
                div_cnt_next  = '0;
                state_next    = ST_DIV;
            end

            ST_DIV:
            begin
                // key, secondary and 2^64-1 reduced mod n side by side
                for (int k = 0; k < DIV_STEP; k++)
                begin
                    rk = mod_step(rk, key_sh_reg[KEY_W-1-k], n_bits_reg);
                    rs = mod_step(rs, sec_sh_reg[KEY_W-1-k], n_bits_reg);
                    ro = mod_step(ro, 1'b1, n_bits_reg);
                end
                rem_key_next  = rk;
                rem_sec_next  = rs;
                rem_ones_next = ro;
                key_sh_next   = key_sh_reg << DIV_STEP;
                sec_sh_next   = sec_sh_reg << DIV_STEP;
                div_cnt_next  = div_cnt_reg + DIV_CW'(1);
                if (div_cnt_reg == DIV_CW'(DIV_ITERS - 1))
                begin
                    state_next = ST_FIX;
                end
            end

            ST_FIX:
            begin
                // 2^64 mod n, subtracted whenever the 64-bit probe sum wraps
                w1 = {1'b0, rem_ones_reg} + (NB + 1)'(1);
                if (w1 == {1'b0, n_bits_reg})
                begin
                    wrap_next = '0;
                end
                else
                begin
                    wrap_next = w1[NB-1:0];
                end
                r_next       = rem_key_reg;
                s_mod_next   = rem_sec_reg;
                h_next       = key_reg;
                iss_cnt_next = '0;
                present_next = (mode_reg == MODE_QUERY);
                state_next   = ST_PROBE;
            end

            ST_PROBE:
            begin
                issue = (iss_cnt_reg < n_hash_reg);

                // read side: one probe issued per cycle
                if (issue)
                begin
                    ram_raddr    = AW'(r_reg >> BIT_SEL_W);
                    rd_addr_next = AW'(r_reg >> BIT_SEL_W);
                    rd_bit_next  = r_reg[BIT_SEL_W-1:0];
                    rd_pend_next = 1'b1;
                    iss_cnt_next = iss_cnt_reg + HASH_COUNT_W'(1);

                    h_sum  = {1'b0, h_reg} + {1'b0, second_reg};
                    h_next = h_sum[KEY_W-1:0];
                    r1 = {1'b0, r_reg} + {1'b0, s_mod_reg};
                    if (r1 >= {1'b0, n_bits_reg})
                    begin
                        r1 = r1 - {1'b0, n_bits_reg};
                    end
                    r2 = r1;
                    if (h_sum[KEY_W])
                    begin
                        r2 = r1 - {1'b0, wrap_reg};
                        if (r2[NB])
                        begin
                            r2 = r2 + {1'b0, n_bits_reg};
                        end
                    end
                    r_next = r2[NB-1:0];
                end

                // modify/write side for the probe read last cycle
                if (rd_pend_reg)
                begin
                    if (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg))
                    begin
                        word = fwd_data_reg;
                    end
                    bit_mask = WORD_W'(1) << rd_bit_reg;
                    if (mode_reg == MODE_INSERT)
                    begin
                        ram_we         = 1'b1;
                        ram_waddr      = rd_addr_reg;
                        ram_wdata      = word | bit_mask;
                        fwd_valid_next = 1'b1;
                        fwd_addr_next  = rd_addr_reg;
                        fwd_data_next  = word | bit_mask;
                    end
                    else if ((word & bit_mask) == '0)
                    begin
                        present_next = 1'b0;
                    end
                end

                if (!issue && !rd_pend_reg)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    if ((mode_reg == MODE_INSERT) && (count_reg != '1))
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    rsp_next.maybe_present = present_reg;
                    rsp_next.stored_count  = count_next;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_item_reg    <= 1'b0;
            clr_cnt_reg     <= '0;
            div_cnt_reg     <= '0;
            iss_cnt_reg     <= '0;
            rd_pend_reg     <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            done_reg        <= 1'b0;
            count_reg       <= '0;
            hash_count_reg  <= HASH_COUNT_RST;
            filter_bits_reg <= FILTER_BITS_RST;
        end
        else
        begin
            state_reg       <= state_next;
            clr_item_reg    <= clr_item_next;
            clr_cnt_reg     <= clr_cnt_next;
            div_cnt_reg     <= div_cnt_next;
            iss_cnt_reg     <= iss_cnt_next;
            rd_pend_reg     <= rd_pend_next;
            fwd_valid_reg   <= fwd_valid_next;
            done_reg        <= done_next;
            count_reg       <= count_next;
            hash_count_reg  <= hash_count_next;
            filter_bits_reg <= filter_bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        key_reg      <= key_next;
        n_hash_reg   <= n_hash_next;
        n_bits_reg   <= n_bits_next;
        prod_lo_reg  <= prod_lo_next;
        prod_hi_reg  <= prod_hi_next;
        second_reg   <= second_next;
        key_sh_reg   <= key_sh_next;
        sec_sh_reg   <= sec_sh_next;
        rem_key_reg  <= rem_key_next;
        rem_sec_reg  <= rem_sec_next;
        rem_ones_reg <= rem_ones_next;
        wrap_reg     <= wrap_next;
        s_mod_reg    <= s_mod_next;
        r_reg        <= r_next;
        h_reg        <= h_next;
        rd_addr_reg  <= rd_addr_next;
        rd_bit_reg   <= rd_bit_next;
        fwd_addr_reg <= fwd_addr_next;
        fwd_data_reg <= fwd_data_next;
        present_reg  <= present_next;
        rsp_reg      <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-hashing bloom filter block. A behavioral
// copy of the filter tracks every probed bit and the insert count, predicts
// the answer of each accepted request, and the answers are checked in order
// as the done strobe marks them. Directed cases cover the default, probe and
// size limits; random traffic under several register settings follows.
// ----------------------------------------------------------------------------
module tb_top;
    import bfdh_pkg::*;

    localparam int         CLK_HALF     = 4;
    localparam int         FILTER_MAX   = 65536;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         MAX_REPORTS  = 10;
    localparam int         KEY_POOL     = 256;
    localparam int         MAX_GAP      = 20;
    localparam int         DRAIN_CYCLES = 64;
    localparam int         LIMIT_CYCLES = 1500000;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     start     = 1'b0;
    logic                     busy;
    req_t                     req       = '0;
    logic                     done;
    rsp_t                     rsp;
    logic                     cfg_we    = 1'b0;
    logic                     cfg_addr  = 1'b0;
    logic [FILTER_BITS_W-1:0] cfg_wdata = '0;

    // behavioral copy of the filter
    bit                       shadow_bits [FILTER_MAX];
    logic [COUNT_W-1:0]       shadow_count;
    logic [HASH_COUNT_W-1:0]  shadow_hashes;
    logic [FILTER_BITS_W-1:0] shadow_size;

    rsp_t                     expected_answers [$];
    logic [KEY_W-1:0]         inserted_keys [$];
    int                       error_count = 0;

    bloom_filter_double_hash_top #(
        .MAX_BITS (FILTER_MAX)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    // applies one request to the shadow filter and returns its answer
    function automatic rsp_t filter_answer(input req_t r);
        rsp_t             res;
        int               probes;
        logic [KEY_W-1:0] span;
        logic [KEY_W-1:0] second;
        logic [KEY_W-1:0] pos;
        res = '0;
        probes = (shadow_hashes > MAX_HASHES) ? MAX_HASHES : int'(shadow_hashes);
        if (shadow_size == 0)
            span = 64'd1;
        else if (shadow_size > FILTER_MAX)
            span = 64'(FILTER_MAX);
        else
            span = 64'(shadow_size);
        second = r.key_hash * 64'(MIX_CONST);
        case (r.mode)
            MODE_INSERT:
            begin
                for (int i = 0; i < probes; i++)
                begin
                    pos = (r.key_hash + 64'(i) * second) % span;
                    shadow_bits[pos] = 1'b1;
                end
                if (shadow_count != '1)
                    shadow_count = shadow_count + 1'b1;
            end
            MODE_QUERY:
            begin
                res.maybe_present = 1'b1;
                for (int i = 0; i < probes && res.maybe_present; i++)
                begin
                    pos = (r.key_hash + 64'(i) * second) % span;
                    if (!shadow_bits[pos])
                        res.maybe_present = 1'b0;
                end
            end
            MODE_CLEAR:
            begin
                foreach (shadow_bits[k])
                    shadow_bits[k] = 1'b0;
                shadow_count = '0;
            end
            default:
            begin
            end
        endcase
        res.stored_count = shadow_count;
        return res;
    endfunction

    // called at a rising edge; returns at the edge that accepts the request
    task automatic send_request(input req_t r, input int idle_pct);
        int gap;
        gap = 0;
        while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            gap++;
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        expected_answers = {expected_answers, filter_answer(r)};
        if (r.mode == MODE_INSERT)
        begin
            inserted_keys = {inserted_keys, r.key_hash};
            if (inserted_keys.size() > KEY_POOL)
                void'(inserted_keys.pop_front());
        end
        else if (r.mode == MODE_CLEAR)
            inserted_keys.delete();
    endtask

    task automatic send_op(input logic [1:0] mode, input logic [KEY_W-1:0] key);
        req_t r;
        r.mode     = mode;
        r.key_hash = key;
        send_request(r, 0);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (expected_answers.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic program_filter(input logic [HASH_COUNT_W-1:0] hashes,
                                  input logic [FILTER_BITS_W-1:0] size);
        wait_drained();
        repeat (4) @(posedge clk);
        // upper data bits are junk for the probe count register
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_HASH_COUNT;
        cfg_wdata <= {11'($urandom), hashes};
        @(posedge clk);
        cfg_addr  <= CFG_FILTER_BITS;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_hashes = hashes;
        shadow_size   = size;
    endtask

    task automatic test_reset_settings();
        send_op(MODE_QUERY, 64'h0);
        send_op(MODE_INSERT, '1);
        send_op(MODE_QUERY, '1);
        send_op(MODE_INSERT, 64'h0);
        send_op(MODE_QUERY, 64'h0);
        send_op(MODE_UNUSED, {$urandom, $urandom});
        send_op(MODE_CLEAR, {$urandom, $urandom});
        send_op(MODE_QUERY, '1);
    endtask

    task automatic test_zero_probes();
        program_filter(6'd0, 17'd65536);
        send_op(MODE_QUERY, {$urandom, $urandom});
        send_op(MODE_INSERT, {$urandom, $urandom});
    endtask

    task automatic test_probe_limit();
        logic [KEY_W-1:0] key;
        key = {$urandom, $urandom};
        program_filter(6'd63, 17'd65536);
        send_op(MODE_INSERT, key);
        send_op(MODE_QUERY, key);
        send_op(MODE_QUERY, ~key);
    endtask

    task automatic test_size_limits();
        logic [KEY_W-1:0] key;
        key = {$urandom, $urandom};
        // size zero folds every probe onto bit zero
        program_filter(6'd4, 17'd0);
        send_op(MODE_INSERT, key);
        send_op(MODE_QUERY, ~key);
        program_filter(6'd4, 17'h1ffff);
        send_op(MODE_INSERT, key);
        send_op(MODE_QUERY, key);
        send_op(MODE_QUERY, {$urandom, $urandom});
        program_filter(6'd2, 17'd1);
        send_op(MODE_CLEAR, key);
        send_op(MODE_QUERY, key);
        send_op(MODE_INSERT, ~key);
        send_op(MODE_QUERY, key);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct);
        req_t r;
        int   roll;
        for (int n = 0; n < count; n++)
        begin
            roll       = $urandom_range(99);
            r.key_hash = {$urandom, $urandom};
            if (roll < 46)
                r.mode = MODE_INSERT;
            else if (roll < 94)
            begin
                r.mode = MODE_QUERY;
                // half the queries look for keys that went in
                if (inserted_keys.size() != 0 && $urandom_range(1) == 1)
                    r.key_hash = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
            end
            else if (roll < 97)
                r.mode = MODE_UNUSED;
            else
                r.mode = MODE_CLEAR;
            send_request(r, idle_pct);
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result at %0t: present %0b count %0d",
                             $realtime, rsp.maybe_present, rsp.stored_count);
            end
            else
            begin
                want = expected_answers.pop_front();
                if (rsp.maybe_present !== want.maybe_present
                    || rsp.stored_count !== want.stored_count)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("mismatch at %0t: present %0b/%0b count %0d/%0d (exp/got)",
                                 $realtime, want.maybe_present, rsp.maybe_present,
                                 want.stored_count, rsp.stored_count);
                end
            end
        end
    end

    initial
    begin
        shadow_hashes = HASH_COUNT_RST;
        shadow_size   = FILTER_BITS_RST;
        shadow_count  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // store sweep after reset
        while (busy)
            @(posedge clk);

        test_reset_settings();
        test_zero_probes();
        test_probe_limit();
        test_size_limits();

        program_filter(6'd3, 17'd65536);
        test_random_traffic(170, 0);
        program_filter(6'd32, 17'd65536);
        test_random_traffic(170, 53);
        program_filter(6'd1, 17'd64);
        test_random_traffic(170, 22);
        program_filter(6'd7, 17'd1000);
        test_random_traffic(170, 0);
        program_filter(6'($urandom_range(63)), 17'($urandom_range(8192)));
        test_random_traffic(170, 53);
        program_filter(6'd12, 17'h1ffff);
        test_random_traffic(170, 22);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_answers.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
